[rtl/core/isfp_pkg.sv]
package isfp_pkg;

  localparam int FEATURE_BITS = 22;
  localparam int NUM_WORDS    = 11;
  localparam int CH_BITS      = 8;
  localparam int WLEN_BITS    = 4;
  localparam int KW_CHARS     = 8;
  localparam int TDATA_IN_W   = 8;
  localparam int TDATA_OUT_W  = ((FEATURE_BITS + 7) / 8) * 8;

  typedef logic [FEATURE_BITS-1:0] fmap_t;
  typedef logic [NUM_WORDS-1:0]    cand_t;
  typedef logic [CH_BITS-1:0]      char_t;
  typedef logic [WLEN_BITS-1:0]    wlen_t;
  typedef logic [KW_CHARS*CH_BITS-1:0] kw_text_t;

  localparam cand_t ALL_CANDS  = '1;
  localparam wlen_t WLEN_MAX   = '1;
  localparam char_t UNDERSCORE = "_";
  localparam char_t NUL        = 8'h00;

  // feature bit positions
  localparam int F_I = 0, F_M = 1, F_A = 2, F_F = 3, F_D = 4, F_Q = 5, F_C = 6;
  localparam int F_B = 7, F_P = 8, F_V = 9, F_H = 10;
  localparam int F_ZBA = 11, F_ZBB = 12, F_ZBC = 13, F_ZBS = 14;
  localparam int F_ZICBOM = 15, F_ZICBOP = 16, F_ZICBOZ = 17;
  localparam int F_ZICSR = 18, F_ZIFENCEI = 19, F_SSTC = 20, F_SVADU = 21;

  // extension names, first character in the top byte, zero padded
  localparam kw_text_t KW_TEXT [NUM_WORDS] = '{
    {"zba", 40'h0}, {"zbb", 40'h0}, {"zbc", 40'h0}, {"zbs", 40'h0},
    {"zicbom", 16'h0}, {"zicbop", 16'h0}, {"zicboz", 16'h0},
    {"sstc", 32'h0}, {"svadu", 24'h0}, {"zicsr", 24'h0}, {"zifencei"}
  };

  localparam wlen_t KW_LEN [NUM_WORDS] = '{
    4'd3, 4'd3, 4'd3, 4'd3, 4'd6, 4'd6, 4'd6, 4'd4, 4'd5, 4'd5, 4'd8
  };

  localparam int KW_BIT [NUM_WORDS] = '{
    F_ZBA, F_ZBB, F_ZBC, F_ZBS, F_ZICBOM, F_ZICBOP, F_ZICBOZ,
    F_SSTC, F_SVADU, F_ZICSR, F_ZIFENCEI
  };

  function automatic char_t to_lower(input char_t c);
    return (c >= "A" && c <= "Z") ? char_t'(c + 8'd32) : c;
  endfunction

  // character k of keyword idx, zero past its end
  function automatic char_t kw_char(input int idx, input wlen_t k);
    kw_text_t t;
    t = KW_TEXT[idx];
    if (k >= wlen_t'(KW_CHARS)) begin
      return NUL;
    end
    return t[(KW_CHARS-1-int'(k))*CH_BITS +: CH_BITS];
  endfunction

  function automatic fmap_t letter_mask(input char_t c);
    fmap_t m;
    m = '0;
    case (c)
      "i": m[F_I] = 1'b1;
      "m": m[F_M] = 1'b1;
      "a": m[F_A] = 1'b1;
      "f": m[F_F] = 1'b1;
      "d": begin
        m[F_D] = 1'b1;
        m[F_F] = 1'b1;
      end
      "q": begin
        m[F_Q] = 1'b1;
        m[F_D] = 1'b1;
        m[F_F] = 1'b1;
      end
      "c": m[F_C] = 1'b1;
      "b": m[F_B] = 1'b1;
      "p": m[F_P] = 1'b1;
      "h": m[F_H] = 1'b1;
      "v": begin
        m[F_V] = 1'b1;
        m[F_D] = 1'b1;
        m[F_F] = 1'b1;
      end
      "g": begin
        m[F_I] = 1'b1;
        m[F_M] = 1'b1;
        m[F_A] = 1'b1;
        m[F_D] = 1'b1;
        m[F_F] = 1'b1;
        m[F_ZICSR] = 1'b1;
        m[F_ZIFENCEI] = 1'b1;
      end
      default: m = '0;
    endcase
    return m;
  endfunction

  // features named by a finished word
  function automatic fmap_t word_hits(input wlen_t len, input cand_t cands);
    fmap_t m;
    m = '0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (cands[i] && len == KW_LEN[i]) begin
        m[KW_BIT[i]] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

[rtl/core/isa_string_feature_parser_top.sv]
// isa string feature parser
//
// input channel s_axis: one character per request in tdata[7:0]; tlast marks the
// final character of a string. characters are taken one per cycle whenever
// tready is high.
// output channel m_axis: one request per string, given when its tlast character
// is taken. tdata[21:0] is the feature map, tuser is the accepted flag.
// the result is registered, valid in the cycle after the tlast character is taken.
// throughput: one character per cycle with tready high; the per-character decode and
// the eleven name compares sit between the input handshake and the result register.
// configuration: cfg_we with cfg_wdata loads the default feature map, which is
// also the current map until a string is accepted.
// reset: rst (synchronous, high) clears the parser state, the current map and
// the result valid flag; the result data itself is not reset.
// stall: a waiting result is held in the result register; one more string can
// be parsed meanwhile, and tready falls only when its tlast character would
// need the still occupied result register.
module isa_string_feature_parser_top
  import isfp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [FEATURE_BITS-1:0] cfg_wdata,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [TDATA_IN_W-1:0]   s_axis_tdata,   // [7:0] ch
  input  logic                    s_axis_tlast,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [TDATA_OUT_W-1:0]  m_axis_tdata,   // [21:0] feature_map, [23:22] zero
  output logic                    m_axis_tuser    // [0] accepted
);

  typedef enum logic [1:0] {PH_PREFIX, PH_LETTERS, PH_WORDS} phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  char_count, char_count_next;
  logic        prefix_ok, prefix_ok_next;
  wlen_t       word_length, word_length_next;
  cand_t       word_candidates, word_candidates_next;
  fmap_t       parsed_map, parsed_map_next;
  fmap_t       current_map;
  logic        stopped, stopped_next;

  logic        out_valid;
  fmap_t       out_map;
  logic        out_acc;

  logic        take;
  char_t       ch;
  char_t       lc;
  fmap_t       final_map;
  logic        acc;

  assign ch            = s_axis_tdata[CH_BITS-1:0];
  assign lc            = to_lower(ch);
  assign s_axis_tready = !out_valid || m_axis_tready || !s_axis_tlast;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    phase_next           = phase;
    char_count_next      = char_count;
    prefix_ok_next       = prefix_ok;
    word_length_next     = word_length;
    word_candidates_next = word_candidates;
    parsed_map_next      = parsed_map;
    stopped_next         = stopped;
    if (!stopped) begin
      if (ch == NUL) begin
        if (phase == PH_WORDS) begin
          parsed_map_next      = parsed_map | word_hits(word_length, word_candidates);
          word_length_next     = '0;
          word_candidates_next = ALL_CANDS;
        end
        stopped_next = 1'b1;
      end else begin
        case (phase)
          PH_PREFIX: begin
            if ((char_count == 3'd0 && ch != "r") || (char_count == 3'd1 && ch != "v")) begin
              prefix_ok_next = 1'b0;
            end
            char_count_next = char_count + 3'd1;
            if (char_count_next >= 3'd4) begin
              phase_next = PH_LETTERS;
            end
          end
          PH_LETTERS: begin
            if (ch == UNDERSCORE) begin
              phase_next = PH_WORDS;
            end else begin
              parsed_map_next = parsed_map | letter_mask(lc);
            end
          end
          PH_WORDS: begin
            if (ch == UNDERSCORE) begin
              parsed_map_next      = parsed_map | word_hits(word_length, word_candidates);
              word_length_next     = '0;
              word_candidates_next = ALL_CANDS;
            end else begin
              for (int i = 0; i < NUM_WORDS; i++) begin
                if (kw_char(i, word_length) != lc) begin
                  word_candidates_next[i] = 1'b0;
                end
              end
              if (word_length != WLEN_MAX) begin
                word_length_next = word_length + wlen_t'(1);
              end
            end
          end
          default: phase_next = phase;
        endcase
      end
    end
    final_map = parsed_map_next;
    if (phase_next == PH_WORDS) begin
      final_map = parsed_map_next | word_hits(word_length_next, word_candidates_next);
    end
    acc = prefix_ok_next && (phase_next != PH_PREFIX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_PREFIX;
      char_count      <= '0;
      prefix_ok       <= 1'b1;
      word_length     <= '0;
      word_candidates <= ALL_CANDS;
      parsed_map      <= '0;
      stopped         <= 1'b0;
      current_map     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (take && s_axis_tlast) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (take && s_axis_tlast && acc) begin
        current_map <= final_map;
      end else if (cfg_we) begin
        current_map <= cfg_wdata;
      end
      if (take) begin
        if (s_axis_tlast) begin
          phase           <= PH_PREFIX;
          char_count      <= '0;
          prefix_ok       <= 1'b1;
          word_length     <= '0;
          word_candidates <= ALL_CANDS;
          parsed_map      <= '0;
          stopped         <= 1'b0;
        end else begin
          phase           <= phase_next;
          char_count      <= char_count_next;
          prefix_ok       <= prefix_ok_next;
          word_length     <= word_length_next;
          word_candidates <= word_candidates_next;
          parsed_map      <= parsed_map_next;
          stopped         <= stopped_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && s_axis_tlast) begin
      out_map <= acc ? final_map : current_map;
      out_acc <= acc;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_OUT_W'(out_map);
  assign m_axis_tuser  = out_acc;

  a_count_after_prefix: assert property (@(posedge clk) disable iff (rst)
    phase != PH_PREFIX |-> char_count == 3'd4)
    else $error("left prefix phase without four characters");

  a_word_idle: assert property (@(posedge clk) disable iff (rst)
    phase != PH_WORDS |-> word_length == '0 && word_candidates == ALL_CANDS)
    else $error("word state busy outside word phase");

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
    else $error("no result after final character");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |-> !(take && s_axis_tlast))
    else $error("waiting result overwritten");

endmodule
